// File: hw/rtl/zssf_pkg.sv
// ----------------------------------------------------------------------------
// zssf_pkg
// Shared constants and types for the zero-sum subarray finder.
// ----------------------------------------------------------------------------
package zssf_pkg;

    localparam int DEF_MAX_LEN    = 32;
    localparam int DEF_DATA_WIDTH = 32;

    // running sum headroom above the element width
    localparam int SUM_EXTRA = 6;

    localparam int IDX_W = 5;
    localparam int CNT_W = 10;

    localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;

    // per-cycle control broadcast to every cell of the chain
    typedef struct packed {
        logic load;    // compare new sum, write entry at current position
        logic shift;   // hit flags move one cell toward the head
    } t_cell_ctl;

endpackage

// File: hw/rtl/zssf_if.sv
// ----------------------------------------------------------------------------
// zssf_in_if / zssf_out_if
// Valid/ready channels for input elements and result beats.
// ----------------------------------------------------------------------------
interface zssf_in_if #(
    parameter int DATA_WIDTH = zssf_pkg::DEF_DATA_WIDTH
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] value;
    logic                  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface zssf_out_if;
    logic                       valid;
    logic                       ready;
    logic [zssf_pkg::IDX_W-1:0] start_index;
    logic [zssf_pkg::IDX_W-1:0] end_index;
    logic [zssf_pkg::CNT_W-1:0] total_count;
    logic                       is_total;
    logic                       overflow;
    logic                       last_result;

    modport source (
        output valid, output start_index, output end_index, output total_count,
        output is_total, output overflow, output last_result, input ready
    );
    modport sink (
        input valid, input start_index, input end_index, input total_count,
        input is_total, input overflow, input last_result, output ready
    );
endinterface

// File: hw/rtl/zssf_cell.sv
// ----------------------------------------------------------------------------
// zssf_cell
// One stored prefix sum with its comparator and a hit flag that is handed
// to the neighboring cell toward the head of the chain.
// ----------------------------------------------------------------------------
module zssf_cell #(
    parameter int SUM_W = zssf_pkg::DEF_DATA_WIDTH + zssf_pkg::SUM_EXTRA,
    parameter int PW    = 6,
    parameter int IDX   = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  zssf_pkg::t_cell_ctl i_ctl,
    input  logic [PW-1:0]       i_pos,
    input  logic [SUM_W-1:0]    i_sum,
    input  logic                i_hit,
    output logic                o_hit
);
    import zssf_pkg::*;

    localparam logic [PW-1:0] CELL_IDX = PW'(IDX);

    logic [SUM_W-1:0] r_sum;
    logic             r_hit;

    // entry is written at its own position, so it never matches that item
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_pos == CELL_IDX)) begin
            r_sum <= i_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.load) begin
            r_hit <= (r_sum == i_sum) && (CELL_IDX < i_pos);
        end else if (i_ctl.shift) begin
            r_hit <= i_hit;
        end
    end

    assign o_hit = r_hit;

endmodule

// File: hw/rtl/zero_sum_subarray_finder.sv
// ----------------------------------------------------------------------------
// zero_sum_subarray_finder
// Prefix-sum zero-sum subarray search over a chain of compare cells.
// ----------------------------------------------------------------------------
// Flow: one element at a time, taken only in idle; after the accept cycle the hit flags
//   shift one cell a cycle toward the head unless a pair beat waits on a full output
//   register, one pair beat at most per cycle, and a closing step sends the total beat
//   on last once the output can take it, or returns to idle.
// Reset: synchronous active low; clears sum, position, count, overflow and
//   hit flags. Stored sums are not cleared and need no clearing pass.
module zero_sum_subarray_finder #(
    parameter int MAX_LEN    = zssf_pkg::DEF_MAX_LEN,
    parameter int DATA_WIDTH = zssf_pkg::DEF_DATA_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    zssf_in_if.sink    i_in,
    zssf_out_if.source o_out
);
    import zssf_pkg::*;

    localparam int SUM_W = DATA_WIDTH + SUM_EXTRA;
    localparam int PW    = $clog2(MAX_LEN + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic             r_state, n_state;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [PW-1:0]    r_pos, n_pos;
    logic [PW-1:0]    r_end, n_end;
    logic [PW-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic             r_last, n_last;
    logic             r_head, n_head;

    logic             r_ovalid;
    logic [IDX_W-1:0] r_ostart;
    logic [IDX_W-1:0] r_oend;
    logic [CNT_W-1:0] r_ocnt;
    logic             r_ototal;
    logic             r_oovf;
    logic             r_olast;

    logic             w_acc;
    logic             w_can_emit;
    logic             w_any;
    logic             w_emit_pair;
    logic             w_emit_total;
    logic [SUM_W-1:0] w_new_sum;
    logic [MAX_LEN:0] w_hit;
    t_cell_ctl        w_ctl;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_can_emit = !r_ovalid || o_out.ready;
    assign w_new_sum  = r_sum + SUM_W'($signed(i_in.value));
    assign w_any      = |w_hit[MAX_LEN-1:0];

    // cell chain, hit flags move toward cell 0 on shift
    assign w_hit[MAX_LEN] = 1'b0;
    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        zssf_cell #(
            .SUM_W (SUM_W),
            .PW    (PW),
            .IDX   (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_pos   (r_pos),
            .i_sum   (w_new_sum),
            .i_hit   (w_hit[k+1]),
            .o_hit   (w_hit[k])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_sum        = r_sum;
        n_pos        = r_pos;
        n_end        = r_end;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_ovf        = r_ovf;
        n_last       = r_last;
        n_head       = r_head;
        w_ctl        = '0;
        w_emit_pair  = 1'b0;
        w_emit_total = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_state = ST_SCAN;
                    n_last  = i_in.last;
                    n_idx   = '0;
                    if (r_pos < PW'(MAX_LEN)) begin
                        w_ctl.load = 1'b1;
                        n_sum      = w_new_sum;
                        n_pos      = r_pos + PW'(1);
                        n_end      = r_pos;
                        // empty prefix before index 0 sits at the head
                        n_head     = (w_new_sum == '0);
                    end else begin
                        n_ovf  = 1'b1;
                        n_head = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                priority if (r_head) begin
                    if (w_can_emit) begin
                        w_emit_pair = 1'b1;
                        w_ctl.shift = 1'b1;
                        n_head      = w_hit[0];
                        n_idx       = r_idx + PW'(1);
                        if (r_cnt != COUNT_MAX) begin
                            n_cnt = r_cnt + CNT_W'(1);
                        end
                    end
                end else if (w_any) begin
                    w_ctl.shift = 1'b1;
                    n_head      = w_hit[0];
                    n_idx       = r_idx + PW'(1);
                end else if (r_last) begin
                    if (w_can_emit) begin
                        w_emit_total = 1'b1;
                        n_state      = ST_IDLE;
                        n_sum        = '0;
                        n_pos        = '0;
                        n_cnt        = '0;
                        n_ovf        = 1'b0;
                        n_last       = 1'b0;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sum   <= '0;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_last  <= 1'b0;
            r_head  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_last  <= n_last;
            r_head  <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end <= n_end;
        r_idx <= n_idx;
    end

    // output register, holds a beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit_pair || w_emit_total) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_pair) begin
            r_ostart <= IDX_W'(r_idx);
            r_oend   <= IDX_W'(r_end);
            r_ocnt   <= '0;
            r_ototal <= 1'b0;
            r_oovf   <= r_ovf;
            r_olast  <= !w_any && !r_last;
        end else if (w_emit_total) begin
            r_ostart <= '0;
            r_oend   <= '0;
            r_ocnt   <= r_cnt;
            r_ototal <= 1'b1;
            r_oovf   <= r_ovf;
            r_olast  <= 1'b1;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.start_index = r_ostart;
    assign o_out.end_index   = r_oend;
    assign o_out.total_count = r_ocnt;
    assign o_out.is_total    = r_ototal;
    assign o_out.overflow    = r_oovf;
    assign o_out.last_result = r_olast;

endmodule
